/* hw/rtl/olte_pkg.sv */
package olte_pkg;

   localparam int POS_BITS   = 6;
   localparam int COUNT_BITS = 7;
   localparam int DATA_BITS  = 32;
   localparam int GROUP_BITS = 8;   // match bits per priority group
   localparam int SUB_BITS   = 3;   // index bits inside one group

   typedef enum logic [2:0] {
      ACT_APPEND    = 3'd0,
      ACT_INSERT    = 3'd1,
      ACT_DROP_LAST = 3'd2,
      ACT_REMOVE_AT = 3'd3,
      ACT_REMOVE_VAL = 3'd4,
      ACT_FIND      = 3'd5,
      ACT_READ      = 3'd6,
      ACT_CLEAR     = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_RANGE    = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic                ins;   // cells above pos take lower neighbor, pos loads key
      logic                rem;   // cells at or above pos take upper neighbor
      logic [POS_BITS-1:0] pos;
   } cell_cmd_type;

endpackage

/* hw/rtl/olte_cell.sv */
module olte_cell #(
   parameter int INDEX     = 0,
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  olte_pkg::cell_cmd_type      cmd,
   input  logic signed [WORD_BITS-1:0] key,
   input  logic signed [WORD_BITS-1:0] prev_word,
   input  logic signed [WORD_BITS-1:0] next_word,
   output logic signed [WORD_BITS-1:0] word,
   output logic                        match
);
   import olte_pkg::*;

   localparam logic [POS_BITS-1:0] IDX = POS_BITS'(INDEX);

   logic signed [WORD_BITS-1:0] word_ff, word_in;
   logic                        match_ff;

   always_comb begin
      word_in = word_ff;
      if (cmd.ins && (IDX > cmd.pos)) begin
         word_in = prev_word;
      end else if (cmd.ins && (IDX == cmd.pos)) begin
         word_in = key;
      end else if (cmd.rem && (IDX >= cmd.pos)) begin
         word_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      match_ff <= (word_ff == key);
   end

   assign word  = word_ff;
   assign match = match_ff;

endmodule

/* hw/rtl/olte_prio.sv */
module olte_prio (
   input  logic [olte_pkg::GROUP_BITS-1:0] bits,
   output logic                            any,
   output logic [olte_pkg::SUB_BITS-1:0]   idx
);
   import olte_pkg::*;

   // lowest set bit wins
   always_comb begin
      idx = '0;
      for (int i = GROUP_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = SUB_BITS'(i);
         end
      end
   end

   assign any = |bits;

endmodule

/* hw/rtl/ordered_list_table_engine.sv */
// Channel   Ports                                           Direction  Handshake
// request   req_action, req_position, req_value_in          in         start & !busy
// response  rsp_status, rsp_data_out, rsp_found_index,      out        rsp_strobe, one cycle
//           rsp_entry_count
//
// Each transaction steps through accept, compare (every cell registers word == key),
// group encode (first match inside groups of 8 cells, registered), execute (final pick,
// cell chain shifts/loads, response registered).
// busy is low again in the cycle rsp_strobe is high, so the next start is taken then.
// Synchronous active-high reset clears the sequencer, the count and the strobe; stored
// words are undefined until written. The receiver cannot stall the response.
module ordered_list_table_engine #(
   parameter int DEPTH     = 32,
   parameter int WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [5:0]         req_position,
   input  logic signed [31:0] req_value_in,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data_out,
   output logic [5:0]         rsp_found_index,
   output logic [6:0]         rsp_entry_count
);
   import olte_pkg::*;

   localparam int IDXW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NGROUP = (DEPTH + GROUP_BITS - 1) / GROUP_BITS;
   localparam logic [COUNT_BITS-1:0] DEPTH_C = COUNT_BITS'(DEPTH);

   typedef enum logic [3:0] {
      SEQ_IDLE = 4'b0001,
      SEQ_CMP  = 4'b0010,
      SEQ_GRP  = 4'b0100,
      SEQ_EXEC = 4'b1000
   } seq_type;

   seq_type state_ff, state_in;

   // latched request
   logic [2:0]           action_ff;
   logic [POS_BITS-1:0]  pos_ff;
   logic signed [31:0]   value_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic signed [WORD_BITS-1:0] key;
   assign key = WORD_BITS'(value_ff);   // sign-extend or truncate to word size

   // cell chain
   cell_cmd_type                cmd;
   logic signed [WORD_BITS-1:0] word [DEPTH];
   logic [DEPTH-1:0]            match_vec;
   logic [DEPTH-1:0]            valid_mask;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [WORD_BITS-1:0] prev_w, next_w;
      if (g == 0) begin : g_first
         assign prev_w = key;
      end else begin : g_mid_lo
         assign prev_w = word[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign next_w = word[g];
      end else begin : g_mid_hi
         assign next_w = word[g+1];
      end
      assign valid_mask[g] = (COUNT_BITS'(g) < count_ff);

      olte_cell #(.INDEX(g), .WORD_BITS(WORD_BITS)) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .key       (key),
         .prev_word (prev_w),
         .next_word (next_w),
         .word      (word[g]),
         .match     (match_vec[g])
      );
   end

   // group stage: first match inside each group of cells
   logic [NGROUP*GROUP_BITS-1:0] match_pad;
   logic [NGROUP-1:0]            grp_any_w;
   logic [NGROUP*SUB_BITS-1:0]   grp_idx_w;
   logic [NGROUP-1:0]            grp_any_ff;
   logic [NGROUP*SUB_BITS-1:0]   grp_idx_ff;

   assign match_pad = (NGROUP*GROUP_BITS)'(match_vec & valid_mask);

   for (genvar g = 0; g < NGROUP; g++) begin : g_grp
      olte_prio u_prio (
         .bits (match_pad[g*GROUP_BITS +: GROUP_BITS]),
         .any  (grp_any_w[g]),
         .idx  (grp_idx_w[g*SUB_BITS +: SUB_BITS])
      );
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_w;
      grp_idx_ff <= grp_idx_w;
   end

   // final pick across groups
   logic                         hit;
   logic [SUB_BITS-1:0]          gsel;
   logic [GROUP_BITS*SUB_BITS-1:0] grp_idx_pad;
   logic [POS_BITS-1:0]          found;

   olte_prio u_prio_top (
      .bits (GROUP_BITS'(grp_any_ff)),
      .any  (hit),
      .idx  (gsel)
   );

   assign grp_idx_pad = (GROUP_BITS*SUB_BITS)'(grp_idx_ff);
   assign found       = {gsel, grp_idx_pad[gsel*SUB_BITS +: SUB_BITS]};

   // execute
   status_type          status_w;
   logic signed [31:0]  data_w;
   logic [POS_BITS-1:0] found_w;

   logic                 rsp_strobe_ff;
   logic [1:0]           rsp_status_ff;
   logic signed [31:0]   rsp_data_ff;
   logic [POS_BITS-1:0]  rsp_found_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   always_comb begin
      cmd      = '0;
      status_w = STAT_OK;
      data_w   = '0;
      found_w  = '0;
      count_in = count_ff;
      if (state_ff == SEQ_EXEC) begin
         case (action_type'(action_ff))
            ACT_APPEND: begin
               if (count_ff >= DEPTH_C) begin
                  status_w = STAT_FULL;
               end else begin
                  cmd.ins  = 1'b1;
                  cmd.pos  = count_ff[POS_BITS-1:0];
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_INSERT: begin
               if (COUNT_BITS'(pos_ff) > count_ff) begin
                  status_w = STAT_RANGE;
               end else if (count_ff >= DEPTH_C) begin
                  status_w = STAT_FULL;
               end else begin
                  cmd.ins  = 1'b1;
                  cmd.pos  = pos_ff;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_DROP_LAST: begin
               if (count_ff == '0) begin
                  status_w = STAT_RANGE;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            ACT_REMOVE_AT: begin
               if (COUNT_BITS'(pos_ff) >= count_ff) begin
                  status_w = STAT_RANGE;
               end else begin
                  cmd.rem  = 1'b1;
                  cmd.pos  = pos_ff;
                  count_in = count_ff - 1'b1;
               end
            end
            ACT_REMOVE_VAL: begin
               if (hit) begin
                  found_w  = found;
                  cmd.rem  = 1'b1;
                  cmd.pos  = found;
                  count_in = count_ff - 1'b1;
               end else begin
                  status_w = STAT_NOTFOUND;
               end
            end
            ACT_FIND: begin
               if (hit) begin
                  found_w = found;
               end else begin
                  status_w = STAT_NOTFOUND;
               end
            end
            ACT_READ: begin
               if (COUNT_BITS'(pos_ff) >= count_ff) begin
                  status_w = STAT_RANGE;
               end else begin
                  // pos < count <= DEPTH, so the low bits address a real cell
                  data_w = 32'(word[pos_ff[IDXW-1:0]]);
               end
            end
            ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      case (state_ff)
         SEQ_IDLE: state_in = start ? SEQ_CMP : SEQ_IDLE;
         SEQ_CMP:  state_in = SEQ_GRP;
         SEQ_GRP:  state_in = SEQ_EXEC;
         SEQ_EXEC: state_in = SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= (state_ff == SEQ_EXEC);
      end
   end

   always_ff @(posedge clock) begin
      if (start && (state_ff == SEQ_IDLE)) begin
         action_ff <= req_action;
         pos_ff    <= req_position;
         value_ff  <= req_value_in;
      end
      if (state_ff == SEQ_EXEC) begin
         rsp_status_ff <= status_w;
         rsp_data_ff   <= data_w;
         rsp_found_ff  <= found_w;
         rsp_count_ff  <= count_in;
      end
   end

   assign busy            = (state_ff != SEQ_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while a transaction is in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entry_count == count_ff))
      else $error("reported count differs from stored count");

   a_exec_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_EXEC) |=> rsp_strobe)
      else $error("execute cycle gave no response");

endmodule

/* verif/ordered_list_table_engine_tb.sv */
`timescale 1ns / 1ps

module ordered_list_table_engine_tb;
   import olte_pkg::*;

   localparam int LIST_DEPTH    = 32;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int DRAIN_CYCLES  = 8;     // outlasts one whole transaction
   localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side

   // One response as the list should report it.
   typedef struct {
      status_type         status;
      logic signed [31:0] data;
      logic [5:0]         found;
      logic [6:0]         count;
   } list_result_type;

   // Mirror of the list contents plus the queue of responses still owed.
   class list_tracker_type;
      logic signed [31:0] words[LIST_DEPTH];
      int                 count;
      list_result_type    owed[$];
      int                 errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // first position holding val, -1 when absent
      function int locate(logic signed [31:0] val);
         for (int i = 0; i < count; i++)
            if (words[i] == val) return i;
         return -1;
      endfunction

      function void close_gap(int at);
         for (int i = at; i + 1 < count; i++)
            words[i] = words[i + 1];
         count--;
      endfunction

      // Apply one accepted request and queue the response it owes.
      function void note_request(action_type act, logic [5:0] pos,
                                 logic signed [31:0] val);
         list_result_type r;
         int              hit;
         r.status = STAT_OK;
         r.data   = '0;
         r.found  = '0;
         case (act)
            ACT_APPEND: begin
               if (count >= LIST_DEPTH) r.status = STAT_FULL;
               else begin
                  words[count] = val;
                  count++;
               end
            end
            ACT_INSERT: begin
               // range check wins over the full check
               if (int'(pos) > count) r.status = STAT_RANGE;
               else if (count >= LIST_DEPTH) r.status = STAT_FULL;
               else begin
                  for (int i = count; i > int'(pos); i--)
                     words[i] = words[i - 1];
                  words[pos] = val;
                  count++;
               end
            end
            ACT_DROP_LAST: begin
               if (count == 0) r.status = STAT_RANGE;
               else count--;
            end
            ACT_REMOVE_AT: begin
               if (int'(pos) >= count) r.status = STAT_RANGE;
               else close_gap(pos);
            end
            ACT_REMOVE_VAL: begin
               hit = locate(val);
               if (hit < 0) r.status = STAT_NOTFOUND;
               else begin
                  r.found = hit[5:0];
                  close_gap(hit);
               end
            end
            ACT_FIND: begin
               hit = locate(val);
               if (hit < 0) r.status = STAT_NOTFOUND;
               else r.found = hit[5:0];
            end
            ACT_READ: begin
               if (int'(pos) >= count) r.status = STAT_RANGE;
               else r.data = words[pos];
            end
            default: count = 0;
         endcase
         r.count = count[6:0];
         owed.push_back(r);
      endfunction

      function void check_response(status_type status, logic signed [31:0] data,
                                   logic [5:0] found, logic [6:0] cnt);
         list_result_type e;
         if (owed.size() == 0) begin
            $display("%0t: response with none outstanding: status %0d count %0d",
                     $time, status, cnt);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            errors++;
         end
         if (data !== e.data) begin
            $display("%0t: data_out expected %0d actual %0d", $time, e.data, data);
            errors++;
         end
         if (found !== e.found) begin
            $display("%0t: found_index expected %0d actual %0d", $time, e.found, found);
            errors++;
         end
         if (cnt !== e.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, e.count, cnt);
            errors++;
         end
      endfunction
   endclass

   // Random traffic leans one way for a while so the list both fills and empties.
   typedef enum int {LEAN_GROW, LEAN_SHRINK, LEAN_EVEN} lean_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_action;
   logic [5:0]         req_position;
   logic signed [31:0] req_value_in;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data_out;
   logic [5:0]         rsp_found_index;
   logic [6:0]         rsp_entry_count;

   list_tracker_type tracker = new();
   int               gap_pct;       // chance in 100 that the sender idles after a transaction
   int               quiet_cycles;

   ordered_list_table_engine dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_value_in    (req_value_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: check the response first, then note a new request; a response always
   // belongs to an older transaction, so both may land on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            tracker.check_response(status_type'(rsp_status), rsp_data_out,
                                   rsp_found_index, rsp_entry_count);
         if (start && !busy)
            tracker.note_request(action_type'(req_action), req_position, req_value_in);
      end
   end

   // Watchdog: a run is hung once quiet_cycles, cleared by any request taken or response given, reaches STALL_LIMIT.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress, stopping", $time);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Drive one request at the falling edge and hold it until the block takes it.
   // start stays high here; any idle gap is opened by the caller afterward.
   task automatic send_item(action_type act, logic [5:0] pos, logic signed [31:0] val);
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_value_in <= val;
      do @(posedge clock); while (busy);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   // Sender holds off until every outstanding response is back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
   endtask

   // Value source: often a word already in the list so finds and removes hit,
   // else a small value (duplicates likely) or a fully random word.
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 45 && tracker.count > 0)
         return tracker.words[$urandom_range(tracker.count - 1)];
      else if (r < 70)
         return $signed(32'($urandom_range(8))) - 32'sd4;
      return $urandom;
   endfunction

   function automatic logic [5:0] pick_position();
      int hi;
      if ($urandom_range(99) < 20) return 6'($urandom_range(63));
      hi = (tracker.count + 1 > 63) ? 63 : tracker.count + 1;
      return 6'($urandom_range(hi));
   endfunction

   function automatic action_type pick_action(lean_type lean);
      int r;
      r = $urandom_range(99);
      if (r < 2) return ACT_CLEAR;
      if (lean == LEAN_GROW && r < 60)
         return ($urandom_range(1) != 0) ? ACT_INSERT : ACT_APPEND;
      if (lean == LEAN_SHRINK && r < 55) begin
         case ($urandom_range(2))
            0:       return ACT_DROP_LAST;
            1:       return ACT_REMOVE_AT;
            default: return ACT_REMOVE_VAL;
         endcase
      end
      return action_type'($urandom_range(6));
   endfunction

   task automatic run_random(int items);
      lean_type lean;
      int       left_in_lean;
      left_in_lean = 0;
      lean         = LEAN_EVEN;
      for (int n = 0; n < items; n++) begin
         if (left_in_lean == 0) begin
            lean         = lean_type'($urandom_range(2));
            left_in_lean = $urandom_range(20, 60);
         end
         left_in_lean--;
         send_item(pick_action(lean), pick_position(), pick_value());
         if ($urandom_range(99) == 0) drain();
         else maybe_idle();
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_action   = ACT_APPEND;
      req_position = '0;
      req_value_in = '0;
      gap_pct      = 6;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-list errors, edge words, insert at the end and in the
      // middle, insert past the end, misses, out-of-range reads and removes, clear.
      send_item(ACT_DROP_LAST,  6'd0,  32'sd0);
      send_item(ACT_READ,       6'd0,  32'sd0);
      send_item(ACT_REMOVE_AT,  6'd0,  32'sd0);
      send_item(ACT_FIND,       6'd0,  32'sd5);
      send_item(ACT_REMOVE_VAL, 6'd0,  32'sd5);
      send_item(ACT_INSERT,     6'd1,  32'sd9);
      send_item(ACT_INSERT,     6'd0,  32'sh7FFF_FFFF);
      send_item(ACT_APPEND,     6'd63, 32'sh8000_0000);
      send_item(ACT_APPEND,     6'd0,  32'sd0);
      send_item(ACT_APPEND,     6'd0,  -32'sd1);
      send_item(ACT_INSERT,     6'd1,  32'sd42);
      send_item(ACT_INSERT,     6'd6,  32'sd3);
      send_item(ACT_INSERT,     6'd5,  32'sd7);
      send_item(ACT_FIND,       6'd0,  -32'sd1);
      send_item(ACT_FIND,       6'd0,  32'sd42);
      send_item(ACT_FIND,       6'd0,  32'sd99);
      send_item(ACT_READ,       6'd63, 32'sd0);
      send_item(ACT_READ,       6'd0,  32'sd0);
      send_item(ACT_READ,       6'd2,  32'sd0);
      send_item(ACT_REMOVE_VAL, 6'd0,  32'sd42);
      send_item(ACT_REMOVE_VAL, 6'd0,  32'sd1234);
      send_item(ACT_REMOVE_AT,  6'd0,  32'sd0);
      send_item(ACT_REMOVE_AT,  6'd3,  32'sd0);
      send_item(ACT_CLEAR,      6'd0,  32'sd0);
      send_item(ACT_DROP_LAST,  6'd0,  32'sd0);
      drain();

      // Sender rarely idle, then mostly idle, then back to back.
      gap_pct = 6;
      run_random(RANDOM_ITEMS / 3);
      drain();
      gap_pct = 81;
      run_random(RANDOM_ITEMS / 3);
      drain();
      gap_pct = 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/olte_pkg.sv
hw/rtl/olte_cell.sv
hw/rtl/olte_prio.sv
hw/rtl/ordered_list_table_engine.sv
verif/ordered_list_table_engine_tb.sv
